@@ hdl/gbs_pkg.sv @@
// Shared constants and types for the greedy box suppression core.
package gbs_pkg;

   localparam int IDX_W       = 9;
   localparam int COORD_W     = 16;
   localparam int THR_W       = 9;
   localparam int BOX_W       = 4 * COORD_W;
   localparam int AREA_W      = 2 * COORD_W;
   localparam int UNION_W     = AREA_W + 1;
   localparam int REQ_TDATA_W = 80;
   localparam int REQ_PAD_W   = REQ_TDATA_W - IDX_W - BOX_W;
   localparam int RSP_TDATA_W = 16;
   localparam int RSP_PAD_W   = RSP_TDATA_W - IDX_W - 1;

   localparam logic [THR_W-1:0] THR_RESET = 9'd77;

   // stored box, x_min in the low bits
   typedef struct packed {
      logic [COORD_W-1:0] y_max;
      logic [COORD_W-1:0] x_max;
      logic [COORD_W-1:0] y_min;
      logic [COORD_W-1:0] x_min;
   } box_type;

endpackage

@@ hdl/greedy_box_suppression_core.sv @@
// Greedy non-maximum suppression for one class list of candidate boxes.
//
// Candidates enter on the req_ stream in non-increasing score order, one word
// per box; req_tlast marks the final box of a class list. Each candidate gives
// exactly one word on the rsp_ stream: its index, a keep flag and the echoed
// tlast. A kept box is appended to the kept-box memory; tlast empties it.
// The IoU threshold (Q1.8) is written on the csr_ channel between items; the
// user must keep to this, as the block itself does not enforce it.
//
// The scan reads the boxes kept so far in the class list, and a suppressing
// match ends it early. The result word is registered once the IoU pipeline
// drains, and the next word can be accepted in the cycle after. The scan is
// bound by the single read port of the kept-box memory, one stored box per
// cycle, feeding a four-stage IoU pipeline. One item is in work at a time.
//
// Reset clears the kept count, the pipeline valids and the output valid and
// loads the threshold with 77 (about 0.3). The memory itself is not cleared:
// only entries below the kept count are ever read. A result waiting on a
// stalled receiver sits in the output register; the next candidate is still
// accepted and scanned, and only its final step waits for the output register.
module greedy_box_suppression_core #(
   parameter int MAX_BOXES = 512
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: box_index[8:0], x_min[24:9], y_min[40:25], x_max[56:41],
   //            y_max[72:57], zero fill [79:73]
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [gbs_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  logic                                 req_tlast,
   // rsp_tdata: out_index[8:0], keep[9], zero fill [15:10]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [gbs_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gbs_pkg::THR_W-1:0]            csr_data
);

   localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int CW = $clog2(MAX_BOXES + 1);
   localparam int CW_MAX = MAX_BOXES;
   localparam int CMP_W = gbs_pkg::THR_W + gbs_pkg::UNION_W;

   typedef enum logic [2:0] {
      IDLE,
      AREA,
      SCAN,
      DRAIN,
      DECIDE
   } state_type;

   state_type state_ff, state_in;

   logic [CW-1:0]             count_ff, count_in;
   logic [CW-1:0]             k_ff;
   logic                      hit_ff;
   logic [gbs_pkg::THR_W-1:0] thr_ff;
   logic                      v1_ff, v2_ff, v3_ff, v4_ff;
   logic                      rsp_tvalid_ff;

   // candidate
   gbs_pkg::box_type          cand_ff, req_box;
   logic [gbs_pkg::IDX_W-1:0] cand_idx_ff;
   logic                      cand_last_ff;
   logic [gbs_pkg::COORD_W-1:0] wa_ff, ha_ff, wa_in, ha_in;
   logic [gbs_pkg::AREA_W-1:0]  area_a_ff;

   // IoU pipeline
   gbs_pkg::box_type            kept_box;
   logic [gbs_pkg::COORD_W-1:0] ox_in, oy_in, wb_in, hb_in;
   logic [gbs_pkg::COORD_W-1:0] ox_ff, oy_ff, wb_ff, hb_ff;
   logic [gbs_pkg::AREA_W-1:0]  ov_ff, area_b_ff, ov3_ff;
   logic [gbs_pkg::UNION_W-1:0] uni_ff, uni_in;
   logic [CMP_W-1:0]            lhs, rhs;
   logic                        hit_now;

   // output word
   logic [gbs_pkg::IDX_W-1:0] rsp_index_ff;
   logic                      rsp_keep_ff;
   logic                      rsp_last_ff;

   logic req_fire, rd_en, out_free, keep_in, ram_we, pipe_busy;
   logic [gbs_pkg::BOX_W-1:0] rd_data;

   // ---------------------------------------------------------------- control
   assign req_tready = (state_ff == IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rd_en      = (state_ff == SCAN) && !hit_ff && (k_ff < count_ff);
   assign pipe_busy  = v1_ff || v2_ff || v3_ff || v4_ff;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign keep_in    = !hit_ff && (count_ff < CW'(CW_MAX));
   assign ram_we     = (state_ff == DECIDE) && out_free && keep_in;

   always_comb begin
      if (cand_last_ff) begin
         count_in = '0;
      end else if (keep_in) begin
         count_in = count_ff + CW'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         IDLE: begin
            if (req_fire) state_in = AREA;
         end
         AREA: begin
            state_in = SCAN;
         end
         SCAN: begin
            if (!rd_en) state_in = DRAIN;
         end
         DRAIN: begin
            if (!pipe_busy) state_in = DECIDE;
         end
         DECIDE: begin
            if (out_free) state_in = IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         count_ff      <= '0;
         k_ff          <= '0;
         hit_ff        <= 1'b0;
         thr_ff        <= gbs_pkg::THR_RESET;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         v4_ff         <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         v1_ff    <= rd_en;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         v4_ff    <= v3_ff;
         if (csr_valid) begin
            thr_ff <= csr_data;
         end
         if ((state_ff == DECIDE) && out_free) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (req_fire) begin
                  k_ff <= '0;
               end
            end
            SCAN: begin
               if (rd_en) k_ff <= k_ff + CW'(1);
            end
            DECIDE: begin
               if (out_free) begin
                  count_ff <= count_in;
               end
            end
            default: ;
         endcase
         if (req_fire) begin
            hit_ff <= 1'b0;
         end else if (v4_ff && hit_now) begin
            hit_ff <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- datapath
   assign req_box = gbs_pkg::box_type'(req_tdata[gbs_pkg::IDX_W +: gbs_pkg::BOX_W]);
   assign wa_in   = (req_box.x_max >= req_box.x_min) ? req_box.x_max - req_box.x_min : '0;
   assign ha_in   = (req_box.y_max >= req_box.y_min) ? req_box.y_max - req_box.y_min : '0;

   assign kept_box = gbs_pkg::box_type'(rd_data);

   always_comb begin
      logic [gbs_pkg::COORD_W-1:0] lo_x, hi_x, lo_y, hi_y;
      lo_x  = (cand_ff.x_min > kept_box.x_min) ? cand_ff.x_min : kept_box.x_min;
      hi_x  = (cand_ff.x_max < kept_box.x_max) ? cand_ff.x_max : kept_box.x_max;
      lo_y  = (cand_ff.y_min > kept_box.y_min) ? cand_ff.y_min : kept_box.y_min;
      hi_y  = (cand_ff.y_max < kept_box.y_max) ? cand_ff.y_max : kept_box.y_max;
      ox_in = (hi_x > lo_x) ? hi_x - lo_x : '0;
      oy_in = (hi_y > lo_y) ? hi_y - lo_y : '0;
      wb_in = (kept_box.x_max >= kept_box.x_min) ? kept_box.x_max - kept_box.x_min : '0;
      hb_in = (kept_box.y_max >= kept_box.y_min) ? kept_box.y_max - kept_box.y_min : '0;
   end

   // overlap never exceeds the stored box area, so no borrow
   assign uni_in = {1'b0, area_a_ff} + {1'b0, area_b_ff} - {1'b0, ov_ff};

   // overlap * 256 > thr * union, a zero union never suppresses
   assign lhs     = {{(CMP_W - gbs_pkg::AREA_W - 8){1'b0}}, ov3_ff, 8'h00};
   assign rhs     = {{gbs_pkg::UNION_W{1'b0}}, thr_ff} * {{gbs_pkg::THR_W{1'b0}}, uni_ff};
   assign hit_now = (uni_ff != '0) && (lhs > rhs);

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cand_ff      <= req_box;
         cand_idx_ff  <= req_tdata[gbs_pkg::IDX_W-1:0];
         cand_last_ff <= req_tlast;
         wa_ff        <= wa_in;
         ha_ff        <= ha_in;
      end
      if (state_ff == AREA) begin
         area_a_ff <= wa_ff * ha_ff;
      end
      ox_ff     <= ox_in;
      oy_ff     <= oy_in;
      wb_ff     <= wb_in;
      hb_ff     <= hb_in;
      ov_ff     <= ox_ff * oy_ff;
      area_b_ff <= wb_ff * hb_ff;
      uni_ff    <= uni_in;
      ov3_ff    <= ov_ff;
      if ((state_ff == DECIDE) && out_free) begin
         rsp_index_ff <= cand_idx_ff;
         rsp_keep_ff  <= keep_in;
         rsp_last_ff  <= cand_last_ff;
      end
   end

   gbs_ram #(
      .WIDTH (gbs_pkg::BOX_W),
      .DEPTH (MAX_BOXES)
   ) u_kept_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (cand_ff),
      .rd_en   (rd_en),
      .rd_addr (k_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{gbs_pkg::RSP_PAD_W{1'b0}}, rsp_keep_ff, rsp_index_ff};
   assign rsp_tlast  = rsp_last_ff;

   // ---------------------------------------------------------------- checks
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (count_ff < CW'(CW_MAX)))
      else $error("kept-box write beyond capacity");

   a_read_below_count: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (k_ff < count_ff))
      else $error("read of an unwritten kept box");

   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !pipe_busy)
      else $error("new word accepted while IoU pipeline busy");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == DECIDE) && out_free && cand_last_ff) |=> (count_ff == '0))
      else $error("kept count not cleared at end of class list");

   a_keep_stored: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == DECIDE) && out_free && keep_in && !cand_last_ff)
         |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("kept box not counted");

endmodule

@@ hdl/gbs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module gbs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 512
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
